>>> design/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

    // input opcodes
    localparam logic C_OP_START = 1'b0;
    localparam logic C_OP_STEP  = 1'b1;

    // configuration register indexes
    localparam logic C_REG_WIDTH  = 1'b0;
    localparam logic C_REG_HEIGHT = 1'b1;

    // screen size after reset
    localparam logic [10:0] C_WIDTH_RESET  = 11'd480;
    localparam logic [10:0] C_HEIGHT_RESET = 11'd800;

    // midpoint decision constants
    localparam logic [11:0] C_DEC_INIT    = 12'd3;
    localparam logic [11:0] C_DEC_INC_POS = 12'd6;
    localparam logic [11:0] C_DEC_INC_NEG = 12'd10;

    // dot index of the eighth dot in a step
    localparam logic [2:0] C_LAST_DOT = 3'd7;

    // one step worth of geometry handed to the dot emitter
    typedef struct packed {
        logic [10:0] x0;
        logic [10:0] y0;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] color;
        logic        done;
    } t_step;

endpackage

`default_nettype wire

>>> design/mcr_step.sv
// ----------------------------------------------------------------------------
// mcr_step
// Circle state and midpoint update; turns each accepted step word into
// the geometry of its eight dots.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_step
    import mcr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_opcode,
    input  wire logic [10:0] i_center_x,
    input  wire logic [10:0] i_center_y,
    input  wire logic [7:0]  i_radius,
    input  wire logic        i_filled,
    input  wire logic [15:0] i_color,
    output logic             o_fire,
    output t_step            o_step
);

    logic        r_busy;
    logic        r_fill_mode;
    logic [10:0] r_origin_x;
    logic [10:0] r_origin_y;
    logic [15:0] r_pen_color;
    logic [7:0]  r_step_a;
    logic [7:0]  r_step_b;
    logic [7:0]  r_inner_pos;
    logic [11:0] r_decision;

    logic        n_busy;
    logic [7:0]  n_step_a;
    logic [7:0]  n_step_b;
    logic [7:0]  n_inner_pos;
    logic [11:0] n_decision;

    logic [8:0]        a_inc;
    logic signed [9:0] b_new;
    logic [11:0]       dec_adv;
    logic              adv_done;
    logic              do_adv;
    logic              done;

    // midpoint update of a, b and the decision
    always_comb begin
        a_inc = {1'b0, r_step_a} + 9'd1;
        if (r_decision[11]) begin
            dec_adv = r_decision + {1'b0, a_inc, 2'b00} + C_DEC_INC_POS;
            b_new   = signed'({2'b00, r_step_b});
        end else begin
            dec_adv = r_decision + C_DEC_INC_NEG
                    + ({1'b0, a_inc, 2'b00} - {2'b00, r_step_b, 2'b00});
            b_new   = signed'({2'b00, r_step_b}) - 10'sd1;
        end
        adv_done = signed'({1'b0, a_inc}) > b_new;
    end

    // filled mode advances only after the last inner row of an a value
    always_comb begin
        do_adv = !r_fill_mode
               || (({1'b0, r_inner_pos} + 9'd1) > {1'b0, r_step_b});
        done   = do_adv && adv_done;
        o_fire = i_accept && (i_opcode == C_OP_STEP) && r_busy;

        o_step.x0    = r_origin_x;
        o_step.y0    = r_origin_y;
        o_step.a     = r_step_a;
        o_step.b     = r_fill_mode ? r_inner_pos : r_step_b;
        o_step.color = r_pen_color;
        o_step.done  = done;
    end

    // next state of the step variables on a step word
    always_comb begin
        n_busy      = r_busy;
        n_step_a    = r_step_a;
        n_step_b    = r_step_b;
        n_inner_pos = r_inner_pos;
        n_decision  = r_decision;
        if (do_adv) begin
            n_step_a    = a_inc[7:0];
            n_step_b    = b_new[7:0];
            n_inner_pos = a_inc[7:0];
            n_decision  = dec_adv;
            n_busy      = !adv_done;
        end else begin
            n_inner_pos = r_inner_pos + 8'd1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fill_mode <= 1'b0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_pen_color <= '0;
            r_step_a    <= '0;
            r_step_b    <= '0;
            r_inner_pos <= '0;
            r_decision  <= '0;
        end else if (i_accept && (i_opcode == C_OP_START)) begin
            r_busy      <= 1'b1;
            r_fill_mode <= i_filled;
            r_origin_x  <= i_center_x;
            r_origin_y  <= i_center_y;
            r_pen_color <= i_color;
            r_step_a    <= '0;
            r_step_b    <= i_radius;
            r_inner_pos <= '0;
            r_decision  <= C_DEC_INIT - {3'b000, i_radius, 1'b0};
        end else if (o_fire) begin
            r_busy      <= n_busy;
            r_step_a    <= n_step_a;
            r_step_b    <= n_step_b;
            r_inner_pos <= n_inner_pos;
            r_decision  <= n_decision;
        end
    end

endmodule

`default_nettype wire

>>> design/mcr_emit.sv
// ----------------------------------------------------------------------------
// mcr_emit
// Holds one step and sends its eight mirrored dots, one per cycle while
// the output does not stall, through an output register with screen clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_emit
    import mcr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire t_step              i_step,
    input  wire logic [10:0]        i_width,
    input  wire logic [10:0]        i_height,
    input  wire logic               i_out_stall,
    output logic                    o_ready,
    output logic                    o_out_valid,
    output logic signed [12:0]      o_dot_x,
    output logic signed [12:0]      o_dot_y,
    output logic [15:0]             o_dot_color,
    output logic                    o_visible,
    output logic                    o_last_of_step,
    output logic                    o_circle_done
);

    t_step       r_buf;
    logic        r_buf_valid;
    logic [2:0]  r_idx;
    logic        r_out_valid;

    logic        adv;
    logic        x_use_b;
    logic        x_neg;
    logic        y_use_b;
    logic        y_neg;
    logic [12:0] x_off;
    logic [12:0] y_off;
    logic [12:0] n_x;
    logic [12:0] n_y;
    logic        n_vis;
    logic        n_last;

    // handshake between buffer and output register
    always_comb begin
        adv     = r_buf_valid && (!r_out_valid || !i_out_stall);
        o_ready = !r_buf_valid || (adv && (r_idx == C_LAST_DOT));
    end

    // octant selection per dot index
    always_comb begin
        x_use_b = 1'b0;
        x_neg   = 1'b0;
        y_use_b = 1'b0;
        y_neg   = 1'b0;
        case (r_idx)
            3'd0: begin y_use_b = 1'b1; y_neg = 1'b1; end
            3'd1: begin x_use_b = 1'b1; y_neg = 1'b1; end
            3'd2: begin x_use_b = 1'b1; end
            3'd3: begin y_use_b = 1'b1; end
            3'd4: begin x_neg = 1'b1; y_use_b = 1'b1; end
            3'd5: begin x_neg = 1'b1; x_use_b = 1'b1; end
            3'd6: begin x_neg = 1'b1; y_use_b = 1'b1; y_neg = 1'b1; end
            default: begin x_neg = 1'b1; x_use_b = 1'b1; y_neg = 1'b1; end
        endcase
    end

    // dot position and clipping
    always_comb begin
        x_off  = {5'b0, (x_use_b ? r_buf.b : r_buf.a)};
        y_off  = {5'b0, (y_use_b ? r_buf.b : r_buf.a)};
        n_x    = x_neg ? ({2'b00, r_buf.x0} - x_off) : ({2'b00, r_buf.x0} + x_off);
        n_y    = y_neg ? ({2'b00, r_buf.y0} - y_off) : ({2'b00, r_buf.y0} + y_off);
        n_vis  = !n_x[12] && !n_y[12]
               && (n_x[11:0] < {1'b0, i_width})
               && (n_y[11:0] < {1'b0, i_height});
        n_last = (r_idx == C_LAST_DOT);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == C_LAST_DOT) begin
                    r_buf_valid <= 1'b0;
                end
            end
            if (i_load) begin
                r_buf_valid <= 1'b1;
                r_idx       <= '0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_step;
        end
        if (adv) begin
            o_dot_x        <= signed'(n_x);
            o_dot_y        <= signed'(n_y);
            o_dot_color    <= r_buf.color;
            o_visible      <= n_vis;
            o_last_of_step <= n_last;
            o_circle_done  <= n_last && r_buf.done;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle rasterizer: start and step words in, clipped dots out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): a start word (opcode 0) loads
//   centre, radius, fill mode and colour and produces no dots. Each step
//   word (opcode 1) produces eight mirrored dots; steps with no circle
//   running are taken and dropped.
//   Output channel (o_out_valid / i_out_stall): one dot per word, with the
//   eighth flagged by last_of_step and, on the final step, circle_done.
//   A taken step goes into the step buffer and its first dot into the
//   dot output register; the other seven follow one per cycle while
//   the output does not stall. With the single dot output register,
//   the next step is taken on the clock that registers the eighth dot.
//   A stall on the output holds the current dot and, once the step buffer
//   is full, stalls the input.
//   Reset (synchronous, active low) ends any circle, empties the buffers
//   and sets the screen to 480 x 800. The user must write the screen size
//   through the cfg port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer
    import mcr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [10:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_opcode,
    input  wire logic [10:0]        i_center_x,
    input  wire logic [10:0]        i_center_y,
    input  wire logic [7:0]         i_radius,
    input  wire logic               i_filled,
    input  wire logic [15:0]        i_color,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [12:0]      o_dot_x,
    output logic signed [12:0]      o_dot_y,
    output logic [15:0]             o_dot_color,
    output logic                    o_visible,
    output logic                    o_last_of_step,
    output logic                    o_circle_done
);

    logic [10:0] r_width;
    logic [10:0] r_height;
    logic        ready;
    logic        accept;
    logic        fire;
    t_step       step;

    // screen size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= C_WIDTH_RESET;
            r_height <= C_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_REG_WIDTH:  r_width  <= i_cfg_data;
                C_REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input handshake
    assign o_in_stall = !ready;
    assign accept     = i_in_valid && ready;

    mcr_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_opcode   (i_opcode),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_filled   (i_filled),
        .i_color    (i_color),
        .o_fire     (fire),
        .o_step     (step)
    );

    mcr_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire),
        .i_step         (step),
        .i_width        (r_width),
        .i_height       (r_height),
        .i_out_stall    (i_out_stall),
        .o_ready        (ready),
        .o_out_valid    (o_out_valid),
        .o_dot_x        (o_dot_x),
        .o_dot_y        (o_dot_y),
        .o_dot_color    (o_dot_color),
        .o_visible      (o_visible),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule

`default_nettype wire

>>> design/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks of the circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [12:0] o_dot_x,
    input  wire logic signed [12:0] o_dot_y,
    input  wire logic [15:0]        o_dot_color,
    input  wire logic               o_visible,
    input  wire logic               o_last_of_step,
    input  wire logic               o_circle_done
);

    // circle end only on the eighth dot
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_circle_done) |-> o_last_of_step)
        else $error("circle_done without last_of_step");

    // visible dots lie in the positive quadrant
    a_vis_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_visible) |-> (!o_dot_x[12] && !o_dot_y[12]))
        else $error("visible dot at negative position");

    // dots of a step follow back to back in one colour
    a_step_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_step)
            |=> (o_out_valid && (o_dot_color == $past(o_dot_color))))
        else $error("step burst broken");

    // stalled dot keeps its position
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_dot_x) && $stable(o_dot_y)))
        else $error("stalled dot changed");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_dot_x        (o_dot_x),
    .o_dot_y        (o_dot_y),
    .o_dot_color    (o_dot_color),
    .o_visible      (o_visible),
    .o_last_of_step (o_last_of_step),
    .o_circle_done  (o_circle_done)
);

`default_nettype wire
